// ===== sv/rfid_tag_frame_decoder_defines.svh =====
// Assertion macros for the tag frame decoder.
// Included by the top level; no other dependencies.
`ifndef RFID_TAG_FRAME_DECODER_DEFINES_SVH
`define RFID_TAG_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define RFIDFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, gated off during reset.
`define RFIDFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rfidfd_pkg.sv =====
// Types, constants and digit decode for the tag frame decoder.
// No dependencies.
package rfidfd_pkg;

   localparam int RxByteWidth   = 8;
   localparam int StatusWidth   = 2;
   localparam int AnimalWidth   = 45;
   localparam int CountryWidth  = 21;
   localparam int GoodCntWidth  = 32;
   localparam int PosWidth      = 5;

   localparam logic [7:0] StxByte = 8'h02;
   localparam logic [7:0] EtxByte = 8'h03;
   localparam logic [7:0] CharA   = 8'h41;
   localparam logic [7:0] Char0   = 8'h30;

   localparam logic [PosWidth-1:0] FrameLen = 5'd30;
   localparam logic [PosWidth-1:0] IdFirst  = 5'd1;
   localparam logic [PosWidth-1:0] IdLast   = 5'd10;
   localparam logic [PosWidth-1:0] CcFirst  = 5'd11;
   localparam logic [PosWidth-1:0] CcLast   = 5'd14;
   localparam logic [PosWidth-1:0] XorLast  = 5'd26;
   localparam logic [PosWidth-1:0] ChkPos   = 5'd27;
   localparam logic [PosWidth-1:0] InvPos   = 5'd28;
   localparam logic [PosWidth-1:0] EtxPos   = 5'd29;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_ETX = 2'd1,
      STATUS_BAD_CHK = 2'd2,
      STATUS_BAD_INV = 2'd3
   } status_type;

   function automatic logic [7:0] digit_value(input logic [7:0] c);
      logic [7:0] n;
      if (c >= CharA) begin
         n = c - CharA + 8'd10;
      end else begin
         n = c - Char0;
      end
      return n;
   endfunction

endpackage

// ===== sv/rfidfd_if.sv =====
// Valid/ready channel interfaces for the tag frame decoder.
// Depends on rfidfd_pkg for field widths.
interface rfidfd_req_if import rfidfd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [RxByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfidfd_rsp_if import rfidfd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [StatusWidth-1:0]  frame_status;
   logic [AnimalWidth-1:0]  tag_number;
   logic [CountryWidth-1:0] country_code;
   logic [GoodCntWidth-1:0] good_frame_count;

   modport source (output valid, output frame_status, output tag_number,
                   output country_code, output good_frame_count, input ready);
   modport sink   (input valid, input frame_status, input tag_number,
                   input country_code, input good_frame_count, output ready);
endinterface

// ===== sv/rfid_tag_frame_decoder.sv =====
// Tag frame decoder: one serial byte per beat, one result beat per 30-byte frame.
// Throughput: one byte per cycle, but the end-marker byte stalls while the last
// result beat is untaken; each byte does at most one 45-bit or 21-bit digit add.
// The result register loads as the end-marker byte leaves the byte register.
// Synchronous active-high reset clears both stage valid flags, the byte position
// (hunting) and the good-frame counter. Depends on rfidfd_pkg, rfidfd_if, defines.
`include "rfid_tag_frame_decoder_defines.svh"

module rfid_tag_frame_decoder import rfidfd_pkg::*; (
   input logic          clock,
   input logic          reset,
   rfidfd_req_if.sink   req_chan,
   rfidfd_rsp_if.source rsp_chan
);

   logic                    byte_valid_ff, byte_valid_in;
   logic [RxByteWidth-1:0]  byte_ff, byte_in;

   logic [PosWidth-1:0]     pos_ff, pos_in;
   logic [7:0]              xor_ff, xor_in;
   logic [AnimalWidth-1:0]  id_ff, id_in;
   logic [CountryWidth-1:0] cc_ff, cc_in;
   logic                    chk_ok_ff, chk_ok_in;
   logic                    inv_ok_ff, inv_ok_in;
   logic [GoodCntWidth-1:0] good_cnt_ff, good_cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   logic [AnimalWidth-1:0]  animal_ff;
   logic [CountryWidth-1:0] country_ff;
   logic [GoodCntWidth-1:0] count_out_ff;

   logic                    hunting;
   logic                    at_end;
   logic                    advance;
   logic                    rsp_load;
   logic                    req_fire;
   logic [7:0]              nibble;
   logic [3:0]              id_idx;
   logic [1:0]              cc_idx;
   logic [AnimalWidth-1:0]  id_term;
   logic [CountryWidth-1:0] cc_term;

   assign hunting  = (pos_ff == '0) || (pos_ff >= FrameLen);
   assign at_end   = !hunting && (pos_ff == EtxPos);
   assign advance  = byte_valid_ff && (!at_end || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !byte_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign nibble  = digit_value(byte_ff);
   assign id_idx  = 4'(pos_ff - IdFirst);
   assign cc_idx  = 2'(pos_ff - CcFirst);
   assign id_term = {{(AnimalWidth-8){1'b0}}, nibble} << {id_idx, 2'b00};
   assign cc_term = {{(CountryWidth-8){1'b0}}, nibble} << {cc_idx, 2'b00};

   always_comb begin
      byte_valid_in = byte_valid_ff;
      byte_in       = byte_ff;
      if (req_fire) begin
         byte_valid_in = 1'b1;
         byte_in       = req_chan.rx_byte;
      end else if (advance) begin
         byte_valid_in = 1'b0;
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      xor_in      = xor_ff;
      id_in       = id_ff;
      cc_in       = cc_ff;
      chk_ok_in   = chk_ok_ff;
      inv_ok_in   = inv_ok_ff;
      good_cnt_in = good_cnt_ff;
      status_in   = STATUS_OK;
      rsp_load    = 1'b0;
      if (advance) begin
         if (hunting) begin
            if (byte_ff == StxByte) begin
               pos_in    = IdFirst;
               xor_in    = '0;
               id_in     = '0;
               cc_in     = '0;
               chk_ok_in = 1'b0;
               inv_ok_in = 1'b0;
            end else begin
               pos_in = '0;
            end
         end else begin
            if (pos_ff <= XorLast) begin
               xor_in = xor_ff ^ byte_ff;
            end
            if (pos_ff <= IdLast) begin
               id_in = id_ff + id_term;
            end else if (pos_ff >= CcFirst && pos_ff <= CcLast) begin
               cc_in = cc_ff + cc_term;
            end else if (pos_ff == ChkPos) begin
               chk_ok_in = (byte_ff == xor_ff);
            end else if (pos_ff == InvPos) begin
               inv_ok_in = (byte_ff == ~xor_ff);
            end
            if (pos_ff != EtxPos) begin
               pos_in = pos_ff + 5'd1;
            end else begin
               pos_in   = '0;
               rsp_load = 1'b1;
               if (byte_ff != EtxByte) begin
                  status_in = STATUS_BAD_ETX;
               end else if (!chk_ok_ff) begin
                  status_in = STATUS_BAD_CHK;
               end else if (!inv_ok_ff) begin
                  status_in = STATUS_BAD_INV;
               end else begin
                  status_in   = STATUS_OK;
                  good_cnt_in = good_cnt_ff + 32'd1;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         pos_ff        <= '0;
         good_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         pos_ff        <= pos_in;
         good_cnt_ff   <= good_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      xor_ff    <= xor_in;
      id_ff     <= id_in;
      cc_ff     <= cc_in;
      chk_ok_ff <= chk_ok_in;
      inv_ok_ff <= inv_ok_in;
      if (rsp_load) begin
         status_ff    <= status_in;
         animal_ff    <= id_in;
         country_ff   <= cc_in;
         count_out_ff <= good_cnt_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.frame_status     = status_ff;
   assign rsp_chan.tag_number       = animal_ff;
   assign rsp_chan.country_code     = country_ff;
   assign rsp_chan.good_frame_count = count_out_ff;

   `RFIDFD_ASSERT_NOW(a_load_only_at_end, clock, reset, rsp_load,
      pos_ff == EtxPos, "result outside end marker")
   `RFIDFD_ASSERT_NOW(a_pos_in_frame, clock, reset, 1'b1,
      pos_ff <= EtxPos, "byte position out of frame")
   `RFIDFD_ASSERT_NEXT(a_good_counts, clock, reset, rsp_load && status_in == STATUS_OK,
      good_cnt_ff == $past(good_cnt_ff) + 32'd1, "good frame not counted")

endmodule
